// ----- src/nds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nds_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int OP_W   = 3;
    localparam int POS_W  = 10;
    localparam int CNT_W  = POS_W + 1;
    localparam int NOTE_W = 32;
    localparam int DUR_W  = 16;
    localparam int SPU_W  = 32;
    localparam int CD_W   = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
    localparam logic [OP_W-1:0] OP_TRIGGER     = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE_NOTE  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE_DUR   = 3'd3;
    localparam logic [OP_W-1:0] OP_RESTART     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_UNIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_MODE      = 8'd1;

    // 192.0 in Q16.16
    localparam logic [SPU_W-1:0] SPU_RESET = 32'd12582912;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  entry_index;
        logic [NOTE_W-1:0] note_word;
        logic [DUR_W-1:0]  duration_units;
        logic              last_entry;
    } item_t;

    typedef struct packed {
        logic              sequence_wrapped;
        logic              note_started;
        logic [POS_W-1:0]  note_position;
        logic [NOTE_W-1:0] note_value;
    } result_t;

    typedef struct packed {
        logic [SPU_W-1:0] samples_per_unit;
        logic             manual_mode;
    } cfg_t;

endpackage

`default_nettype wire

// ----- src/nds_table_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nds_table_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/nds_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nds_core
    import nds_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire item_t   item,
    input  wire logic    item_fire,
    input  wire cfg_t    cfg,
    output result_t      result
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Returns {wrapped, next position}
    function automatic logic [POS_W:0] advance_pos(input logic [POS_W-1:0] pos,
                                                   input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] nxt;
        nxt = {1'b0, pos} + CNT_W'(1);
        if (nxt >= count) begin
            return {1'b1, POS_W'(0)};
        end
        return {1'b0, nxt[POS_W-1:0]};
    endfunction

    logic [CNT_W-1:0]  note_count_reg, note_count_next;
    logic [CNT_W-1:0]  duration_count_reg, duration_count_next;
    logic [POS_W-1:0]  note_pos_reg, note_pos_next;
    logic [POS_W-1:0]  duration_pos_reg, duration_pos_next;
    logic [CD_W-1:0]   countdown_reg, countdown_next;
    logic [NOTE_W-1:0] held_note_reg, held_note_next;
    logic              trigger_pending_reg, trigger_pending_next;
    logic [NOTE_W-1:0] note0_reg;

    // The tables are read ahead, at the position after the current one;
    // a write landing on that address in the same cycle is forwarded.
    logic              note_byp_reg, dur_byp_reg;
    logic [NOTE_W-1:0] note_byp_data_reg;
    logic [DUR_W-1:0]  dur_byp_data_reg;
    logic [NOTE_W-1:0] note_ram_rdata, note_ahead;
    logic [DUR_W-1:0]  dur_ram_rdata, dur_ahead;

    logic              idx_ok;
    logic              note_we, dur_we;
    logic [AW-1:0]     waddr;
    logic [POS_W:0]    note_adv, dur_adv, note_rd_adv, dur_rd_adv;
    logic [AW-1:0]     note_raddr, dur_raddr;
    logic [47:0]       prod;
    logic [CD_W-1:0]   reload;
    logic              started, wrapped;

    assign idx_ok  = 32'(item.entry_index) < 32'(TABLE_DEPTH);
    assign note_we = item_fire && (item.op == OP_WRITE_NOTE) && idx_ok;
    assign dur_we  = item_fire && (item.op == OP_WRITE_DUR) && idx_ok;
    assign waddr   = AW'(item.entry_index);

    assign note_ahead = note_byp_reg ? note_byp_data_reg : note_ram_rdata;
    assign dur_ahead  = dur_byp_reg ? dur_byp_data_reg : dur_ram_rdata;

    assign note_adv = advance_pos(note_pos_reg, note_count_reg);
    assign dur_adv  = advance_pos(duration_pos_reg, duration_count_reg);

    assign prod   = {32'd0, dur_ahead} * {16'd0, cfg.samples_per_unit};
    assign reload = prod[47:16];

    always_comb begin
        note_count_next      = note_count_reg;
        duration_count_next  = duration_count_reg;
        note_pos_next        = note_pos_reg;
        duration_pos_next    = duration_pos_reg;
        countdown_next       = countdown_reg;
        held_note_next       = held_note_reg;
        trigger_pending_next = trigger_pending_reg;
        started              = 1'b0;
        wrapped              = 1'b0;
        if (item_fire) begin
            case (item.op)
                OP_TICK: begin
                    if (cfg.manual_mode) begin
                        if (trigger_pending_reg) begin
                            trigger_pending_next = 1'b0;
                            if (note_count_reg != '0) begin
                                note_pos_next  = note_adv[POS_W-1:0];
                                wrapped        = note_adv[POS_W];
                                held_note_next = note_ahead;
                                started        = 1'b1;
                            end
                        end
                    end else if (countdown_reg != '0) begin
                        countdown_next = countdown_reg - CD_W'(1);
                    end else if (note_count_reg != '0 && duration_count_reg != '0) begin
                        note_pos_next     = note_adv[POS_W-1:0];
                        wrapped           = note_adv[POS_W];
                        duration_pos_next = dur_adv[POS_W-1:0];
                        countdown_next    = reload;
                        held_note_next    = note_ahead;
                        started           = 1'b1;
                    end
                end
                OP_TRIGGER: begin
                    trigger_pending_next = 1'b1;
                end
                OP_WRITE_NOTE: begin
                    if (idx_ok && item.last_entry) begin
                        note_count_next = {1'b0, item.entry_index} + CNT_W'(1);
                        note_pos_next   = item.entry_index;
                    end
                end
                OP_WRITE_DUR: begin
                    if (idx_ok && item.last_entry) begin
                        duration_count_next = {1'b0, item.entry_index} + CNT_W'(1);
                        duration_pos_next   = item.entry_index;
                    end
                end
                OP_RESTART: begin
                    countdown_next = '0;
                    if (note_count_reg != '0) begin
                        note_pos_next  = POS_W'(note_count_reg - CNT_W'(1));
                        held_note_next = note0_reg;
                    end else begin
                        note_pos_next = '0;
                    end
                    if (duration_count_reg != '0) begin
                        duration_pos_next = POS_W'(duration_count_reg - CNT_W'(1));
                    end else begin
                        duration_pos_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign note_rd_adv = advance_pos(note_pos_next, note_count_next);
    assign dur_rd_adv  = advance_pos(duration_pos_next, duration_count_next);
    assign note_raddr  = AW'(note_rd_adv[POS_W-1:0]);
    assign dur_raddr   = AW'(dur_rd_adv[POS_W-1:0]);

    assign result.note_value       = held_note_next;
    assign result.note_position    = note_pos_next;
    assign result.note_started     = started;
    assign result.sequence_wrapped = wrapped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_count_reg      <= '0;
            duration_count_reg  <= '0;
            note_pos_reg        <= '0;
            duration_pos_reg    <= '0;
            countdown_reg       <= '0;
            held_note_reg       <= '0;
            trigger_pending_reg <= 1'b0;
            note_byp_reg        <= 1'b0;
            dur_byp_reg         <= 1'b0;
        end else begin
            note_count_reg      <= note_count_next;
            duration_count_reg  <= duration_count_next;
            note_pos_reg        <= note_pos_next;
            duration_pos_reg    <= duration_pos_next;
            countdown_reg       <= countdown_next;
            held_note_reg       <= held_note_next;
            trigger_pending_reg <= trigger_pending_next;
            note_byp_reg        <= note_we && (waddr == note_raddr);
            dur_byp_reg         <= dur_we && (waddr == dur_raddr);
        end
    end

    always_ff @(posedge aclk) begin
        note_byp_data_reg <= item.note_word;
        dur_byp_data_reg  <= item.duration_units;
        if (note_we && item.entry_index == '0) begin
            note0_reg <= item.note_word;
        end
    end

    nds_table_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_note_ram (
        .aclk  (aclk),
        .we    (note_we),
        .waddr (waddr),
        .wdata (item.note_word),
        .raddr (note_raddr),
        .rdata (note_ram_rdata)
    );

    nds_table_ram #(
        .WIDTH (DUR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_dur_ram (
        .aclk  (aclk),
        .we    (dur_we),
        .waddr (waddr),
        .wdata (item.duration_units),
        .raddr (dur_raddr),
        .rdata (dur_ram_rdata)
    );

endmodule

`default_nettype wire

// ----- src/note_duration_step_sequencer_top.sv -----
// Note/duration step sequencer.
// Commands arrive on the s_ stream: op in s_tuser (tick, trigger, write note,
// write duration, restart), the table index and data in s_tdata, and the
// last-entry flag in s_tlast. Each tick transfer returns one m_ transfer with
// the current note word, its table position and the started/wrapped flags;
// other ops return nothing. Settings go through the cfg_ write channel (index 0
// samples per unit, Q16.16; index 1 manual mode); the user must write them only
// while the block is idle; the block itself does not enforce this.
// Timing: one item per cycle sustained while tick results are taken. An item is
// registered on acceptance and then processed by the core, which loads a tick
// result into the output register. The tables are single RAMs each, read one
// position ahead of the playing note so an advance never waits on a read.
// When m_tready is low, a pending result holds; further ticks wait in the input
// register, and non-tick ops keep flowing only until a tick waits there.
// Reset (aresetn low, synchronous) clears positions, lengths, countdown, held
// note and the pending trigger, and restores the settings to their defaults.
// Table contents are not cleared and must be written before they are played.
`timescale 1ns / 1ps
`default_nettype none

module note_duration_step_sequencer_top
    import nds_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [9:0] entry_index, [41:10] note_word, [57:42] duration_units, [63:58] zero
    input  wire logic [63:0]           s_tdata,
    // [2:0] op
    input  wire logic [OP_W-1:0]       s_tuser,
    input  wire logic                  s_tlast,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] note_value, [41:32] note_position, [42] note_started,
    // [43] sequence_wrapped, [47:44] zero
    output logic      [47:0]           m_tdata,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    cfg_t    cfg_reg;

    logic    fire;
    logic    out_load;
    result_t core_result;

    assign fire = in_valid_reg &&
                  ((in_item_reg.op != OP_TICK) || !out_valid_reg || m_tready);
    assign out_load = fire && (in_item_reg.op == OP_TICK);
    assign s_tready = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.samples_per_unit <= SPU_RESET;
            cfg_reg.manual_mode      <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SAMPLES_PER_UNIT: cfg_reg.samples_per_unit <= cfg_data;
                    REG_MANUAL_MODE:      cfg_reg.manual_mode      <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op             <= s_tuser;
            in_item_reg.entry_index    <= s_tdata[9:0];
            in_item_reg.note_word      <= s_tdata[41:10];
            in_item_reg.duration_units <= s_tdata[57:42];
            in_item_reg.last_entry     <= s_tlast;
        end
        if (out_load) begin
            out_result_reg <= core_result;
        end
    end

    nds_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (in_item_reg),
        .item_fire (fire),
        .cfg       (cfg_reg),
        .result    (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_result_reg.sequence_wrapped,
                       out_result_reg.note_started,
                       out_result_reg.note_position,
                       out_result_reg.note_value};

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import nds_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    // Keeps its own copy of the tables, positions, countdown and settings, and
    // queues the result each tick transfer should return.
    class tick_scoreboard;
        logic [NOTE_W-1:0] note_mem [TABLE_DEPTH_DEF];
        logic [DUR_W-1:0]  dur_mem [TABLE_DEPTH_DEF];
        int unsigned       note_len, dur_len, note_at, dur_at;
        logic [CD_W-1:0]   wait_left;
        logic [NOTE_W-1:0] playing;
        bit                trig_held;
        logic [SPU_W-1:0]  spu;
        bit                manual;
        result_t           tick_results_due[$];
        int                errors, ticks_checked, starts_seen, wraps_seen;

        function new();
            note_len = 0;
            dur_len = 0;
            note_at = 0;
            dur_at = 0;
            wait_left = '0;
            playing = '0;
            trig_held = 1'b0;
            spu = SPU_RESET;
            manual = 1'b0;
            errors = 0;
            ticks_checked = 0;
            starts_seen = 0;
            wraps_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SAMPLES_PER_UNIT: spu = val;
                REG_MANUAL_MODE: manual = val[0];
                default: ;
            endcase
        endfunction

        function int due();
            return tick_results_due.size();
        endfunction

        function int unsigned step_pos(int unsigned pos, int unsigned len);
            return (pos + 1 >= len) ? 0 : pos + 1;
        endfunction

        // duration * Q16.16 factor, truncated, saturated to the countdown width
        function logic [CD_W-1:0] note_ticks(logic [DUR_W-1:0] units);
            logic [63:0] prod;
            prod = (64'(units) * 64'(spu)) >> 16;
            return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[CD_W-1:0];
        endfunction

        function void accept_command(item_t c);
            result_t     r;
            int unsigned idx;
            idx = c.entry_index;
            case (c.op)
                OP_TICK: begin
                    r = '0;
                    if (manual) begin
                        if (trig_held) begin
                            trig_held = 1'b0;
                            if (note_len != 0) begin
                                note_at = step_pos(note_at, note_len);
                                r.sequence_wrapped = (note_at == 0);
                                r.note_started = 1'b1;
                                playing = note_mem[note_at];
                            end
                        end
                    end else if (wait_left != 0) begin
                        wait_left = wait_left - 1;
                    end else if (note_len != 0 && dur_len != 0) begin
                        note_at = step_pos(note_at, note_len);
                        dur_at = step_pos(dur_at, dur_len);
                        r.sequence_wrapped = (note_at == 0);
                        r.note_started = 1'b1;
                        wait_left = note_ticks(dur_mem[dur_at]);
                        playing = note_mem[note_at];
                    end
                    r.note_value = playing;
                    r.note_position = POS_W'(note_at);
                    tick_results_due.push_back(r);
                end
                OP_TRIGGER: trig_held = 1'b1;
                OP_WRITE_NOTE: begin
                    note_mem[idx] = c.note_word;
                    if (c.last_entry) begin
                        note_len = idx + 1;
                        note_at = idx;
                    end
                end
                OP_WRITE_DUR: begin
                    dur_mem[idx] = c.duration_units;
                    if (c.last_entry) begin
                        dur_len = idx + 1;
                        dur_at = idx;
                    end
                end
                OP_RESTART: begin
                    wait_left = '0;
                    note_at = (note_len != 0) ? note_len - 1 : 0;
                    dur_at = (dur_len != 0) ? dur_len - 1 : 0;
                    if (note_len != 0) begin
                        playing = note_mem[0];
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_tick(logic [47:0] data);
            result_t got, want;
            got = result_t'(data[43:0]);
            if (tick_results_due.size() == 0) begin
                $display("%0t: tick result with nothing expected: value %h pos %0d %s %b %s %b",
                         $time, got.note_value, got.note_position, "start",
                         got.note_started, "wrap", got.sequence_wrapped);
                errors++;
                return;
            end
            want = tick_results_due.pop_front();
            ticks_checked++;
            if (got != want) begin
                $display("%0t: mismatch expected value %h pos %0d start %b wrap %b,",
                         $time, want.note_value, want.note_position, want.note_started,
                         want.sequence_wrapped);
                $display("%0t:   got value %h pos %0d start %b wrap %b",
                         $time, got.note_value, got.note_position, got.note_started,
                         got.sequence_wrapped);
                errors++;
            end else begin
                starts_seen += got.note_started;
                wraps_seen += got.sequence_wrapped;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [63:0]           s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  s_tlast = 1'b0;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire  [47:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    wire                   cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tick_scoreboard sb;

    // stimulus side bookkeeping: which entries hold data, so no table length
    // ever covers an entry that was never written
    bit note_written [TABLE_DEPTH_DEF];
    bit dur_written [TABLE_DEPTH_DEF];
    int unsigned note_prefix = 0;
    int unsigned dur_prefix = 0;
    int unsigned dur_cap = 3;
    int cmds_sent = 0;
    int tx_stretch = 0;
    int tx_pct = 0;
    int rx_stretch = 0;
    int rx_pct = 0;
    int rx_hold = 0;

    note_duration_step_sequencer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // mostly short notes; now and then any 16-bit duration
    function automatic logic [DUR_W-1:0] pick_units();
        if ($urandom_range(0, 99) < 85) begin
            return DUR_W'($urandom_range(0, dur_cap));
        end
        return DUR_W'($urandom);
    endfunction

    // Result side: stretches of steady ready alternate with stretches of stalls.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_tick(m_tdata);
        end
        if (rx_stretch == 0) begin
            rx_stretch = $urandom_range(30, 200);
            rx_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
        end
        rx_stretch--;
        if (rx_hold == 0 && $urandom_range(0, 99) < rx_pct) begin
            rx_hold = pick_gap();
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input int unsigned idx,
                            input logic [NOTE_W-1:0] word, input logic [DUR_W-1:0] units,
                            input bit last);
        item_t c;
        int    gap;
        c.op = op;
        c.entry_index = POS_W'(idx);
        c.note_word = word;
        c.duration_units = units;
        c.last_entry = last;
        if (op == OP_WRITE_NOTE) begin
            note_written[idx] = 1'b1;
            while (note_prefix < TABLE_DEPTH_DEF && note_written[note_prefix]) note_prefix++;
        end else if (op == OP_WRITE_DUR) begin
            dur_written[idx] = 1'b1;
            while (dur_prefix < TABLE_DEPTH_DEF && dur_written[dur_prefix]) dur_prefix++;
        end
        if (tx_stretch == 0) begin
            tx_stretch = $urandom_range(20, 120);
            tx_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
        end
        tx_stretch--;
        gap = ($urandom_range(0, 99) < tx_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c.op;
        s_tlast <= c.last_entry;
        s_tdata <= {6'b0, c.duration_units, c.note_word, c.entry_index};
        do @(posedge aclk); while (!s_tready);
        sb.accept_command(c);
        if (op <= OP_RESTART) begin
            cmds_sent++;
        end
    endtask

    // op with random filler in the fields it ignores
    task automatic send_bare(input logic [OP_W-1:0] op);
        send_cmd(op, $urandom_range(0, TABLE_DEPTH_DEF - 1), $urandom, DUR_W'($urandom),
                 1'($urandom));
    endtask

    task automatic tick();
        send_bare(OP_TICK);
    endtask

    // writes entries 0..n-1 and closes the table on the last one
    task automatic load_table(input bit to_notes, input int n);
        for (int i = 0; i < n; i++) begin
            send_cmd(to_notes ? OP_WRITE_NOTE : OP_WRITE_DUR, i, $urandom, pick_units(),
                     i == n - 1);
        end
    endtask

    task automatic random_write(input bit to_notes);
        int unsigned idx, prefix;
        bit          last;
        idx = $urandom_range(0, TABLE_DEPTH_DEF - 1);
        last = ($urandom_range(0, 3) == 0);
        prefix = to_notes ? note_prefix : dur_prefix;
        if (last && idx > prefix) begin
            idx = $urandom_range(0, (prefix < TABLE_DEPTH_DEF) ? prefix : TABLE_DEPTH_DEF - 1);
        end
        send_cmd(to_notes ? OP_WRITE_NOTE : OP_WRITE_DUR, idx, $urandom, pick_units(), last);
    endtask

    task automatic random_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            load_table(1'($urandom_range(0, 1)),
                       ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 48));
        end else if (r < 62) begin
            tick();
        end else if (r < 70) begin
            send_bare(OP_TRIGGER);
        end else if (r < 78) begin
            random_write(1'b1);
        end else if (r < 86) begin
            random_write(1'b0);
        end else if (r < 94) begin
            send_bare(OP_RESTART);
        end else begin
            send_bare(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)));
        end
    endtask

    // Non-tick ops give no transfer back, so the wait runs on past the last due tick
    // transfer to cover any still in the input and processing registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.due() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic begin_phase(input logic [SPU_W-1:0] spu, input bit manual);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= REG_SAMPLES_PER_UNIT;
        cfg_data <= spu;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(REG_SAMPLES_PER_UNIT, spu);
        cfg_index <= REG_MANUAL_MODE;
        cfg_data <= CFG_DATA_W'(manual);
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(REG_MANUAL_MODE, CFG_DATA_W'(manual));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [SPU_W-1:0] spu, input bit manual,
                             input int unsigned cap, input int n);
        int first;
        begin_phase(spu, manual);
        dur_cap = cap;
        first = cmds_sent;
        if ($urandom_range(0, 1) == 1) begin
            load_table(1'b1, $urandom_range(1, 8));
            load_table(1'b0, $urandom_range(1, 8));
        end
        while (cmds_sent - first < n) random_command();
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // manual trigger while the note table is still empty: consumed, note held
        begin_phase(32'h0001_0000, 1'b1);
        tick();
        send_cmd(OP_TRIGGER, 0, '0, '0, 1'b0);
        tick();

        // automatic mode; this trigger stays pending until manual mode returns
        begin_phase(32'h0001_0000, 1'b0);
        send_cmd(OP_TRIGGER, 0, '0, '0, 1'b0);
        send_cmd(OP_UNUSED_HI, TABLE_DEPTH_DEF - 1, '1, '1, 1'b1);
        send_cmd(OP_WRITE_NOTE, 0, 32'hFFFF_FFFF, '0, 1'b0);
        send_cmd(OP_WRITE_NOTE, 1, 32'h0000_0000, '0, 1'b0);
        send_cmd(OP_WRITE_NOTE, 2, 32'h5A5A_A5A5, '0, 1'b1);
        tick();  // duration table still empty
        send_cmd(OP_WRITE_DUR, 0, '0, 16'd0, 1'b0);
        send_cmd(OP_WRITE_DUR, 1, '0, 16'd2, 1'b1);
        repeat (5) tick();
        send_cmd(OP_WRITE_NOTE, TABLE_DEPTH_DEF - 1, 32'h8000_0001, '0, 1'b0);
        send_cmd(OP_WRITE_DUR, TABLE_DEPTH_DEF - 1, '0, 16'hFFFF, 1'b0);
        send_cmd(OP_RESTART, 0, '0, '0, 1'b0);
        tick();

        // largest factor with the longest duration, broken up by restarts
        begin_phase(32'hFFFF_FFFF, 1'b0);
        send_cmd(OP_WRITE_DUR, 0, '0, 16'hFFFF, 1'b0);
        send_cmd(OP_RESTART, 0, '0, '0, 1'b0);
        repeat (3) tick();
        send_cmd(OP_RESTART, 0, '0, '0, 1'b0);
        tick();

        // manual mode picks up the old pending trigger; one-entry table wraps each step
        begin_phase(32'h0000_0000, 1'b1);
        tick();
        tick();
        send_cmd(OP_TRIGGER, 0, '0, '0, 1'b0);
        send_cmd(OP_TRIGGER, 0, '0, '0, 1'b0);
        tick();
        send_cmd(OP_WRITE_NOTE, 0, 32'h0F0F_F0F0, '0, 1'b1);
        send_cmd(OP_TRIGGER, 0, '0, '0, 1'b0);
        tick();

        run_phase(32'h0000_0000, 1'b0, 3, 100);
        run_phase(32'h0000_8000, 1'b0, 3, 100);
        run_phase($urandom_range(0, 32'h0003_0000), 1'b0, 3, 100);
        run_phase(32'h0001_0000, 1'b1, 3, 100);
        run_phase(32'hFFFF_FFFF, 1'b0, 0, 50);
        run_phase(SPU_RESET, 1'b0, 0, 50);
        run_phase($urandom_range(0, 32'h0002_0000), 1'($urandom_range(0, 1)), 3, 100);
        drain();

        $display("summary: %0d commands sent, %0d tick transfers checked", cmds_sent,
                 sb.ticks_checked);
        $display("summary: %0d note starts and %0d wraps seen over eleven register settings",
                 sb.starts_seen, sb.wraps_seen);
        if (sb.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d tick transfers outstanding", sb.due());
        $display("testbench: errors");
        $finish;
    end

endmodule

// ----- note_duration_step_sequencer_top.f -----
src/nds_pkg.sv
src/nds_table_ram.sv
src/nds_core.sv
src/note_duration_step_sequencer_top.sv
tb/testbench.sv
